FILE: rtl/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
package ffra_pkg;

    localparam int unsigned MAX_REGIONS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CHECK   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    localparam logic [0:0] CFG_BASE = 1'b0;
    localparam logic [0:0] CFG_LEN  = 1'b1;

    // one region entry
    typedef struct packed {
        logic        valid;
        logic        used;
        logic [31:0] start;
        logic [31:0] length;
    } t_entry;

    // command broadcast from the controller to every cell
    typedef enum logic [2:0] {
        CC_HOLD,
        CC_SEED,
        CC_SHIFT_UP,   // cells at index > k take neighbor below
        CC_SHIFT_DOWN, // cells at index >= k take neighbor above
        CC_WRITE       // cell k takes the write data
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [7:0]  k;
        t_entry      wdata;
    } t_cell_cmd;

endpackage

FILE: rtl/ffra_cell.sv
// One region cell: holds an entry and moves it to or from its neighbors.
module ffra_cell import ffra_pkg::*; #(
    parameter int unsigned IDX    = 0,
    parameter int unsigned IDX_W  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_seed,
    input  t_entry    i_below,
    input  t_entry    i_above,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic [IDX_W-1:0] w_k;
    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
    // cell 0 comes out of reset as the one valid, empty region
    localparam t_entry RstEntry = '{valid: (IDX == 0), used: 1'b0, start: '0, length: '0};

    assign w_k = i_cmd.k[IDX_W-1:0];

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            CC_SEED:       n_entry = (IDX == 0) ? i_seed : '0;
            CC_SHIFT_UP:   if (MyIdx > w_k) n_entry = i_below;
            CC_SHIFT_DOWN: if (MyIdx >= w_k) n_entry = i_above;
            CC_WRITE:      if (MyIdx == w_k) n_entry = i_cmd.wdata;
            default:       n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= RstEntry;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: rtl/ffra_chain.sv
// Row of region cells linked to their neighbors.
module ffra_chain import ffra_pkg::*; #(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int unsigned IDX_W       = $clog2(MAX_REGIONS)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_seed,
    output t_entry    o_entries [MAX_REGIONS]
);

    t_entry w_e [MAX_REGIONS];

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        t_entry w_below, w_above;
        if (g == 0) begin : g_lo
            assign w_below = '0;
        end else begin : g_mid
            assign w_below = w_e[g-1];
        end
        if (g == MAX_REGIONS - 1) begin : g_hi
            assign w_above = '0;
        end else begin : g_top
            assign w_above = w_e[g+1];
        end
        ffra_cell #(.IDX(g), .IDX_W(IDX_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_seed  (i_seed),
            .i_below (w_below),
            .i_above (w_above),
            .o_entry (w_e[g])
        );
        assign o_entries[g] = w_e[g];
    end

endmodule

FILE: rtl/first_fit_region_allocator_top.sv
// Top level of the first-fit region allocator: sequencer plus cell row.
//
//  channel  | signals                                        | flow
//  ---------+------------------------------------------------+-------------
//  request  | i_start, o_busy, i_action, i_request_size,     | start & !busy
//           | i_target_address                               |
//  result   | o_done, o_status, o_region_start,              | one-cycle strobe
//           | o_region_length, o_is_allocated                |
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index,         | valid & ready
//           | i_cfg_data                                     |
//
// A request scans one cell per cycle from cell 0 to cell MAX_REGIONS - 1,
// then S_EVAL decides and S_REPLY replies; a split adds two cell writes, a
// release hit adds three merge steps. o_done rises in the cycle o_busy
// falls. After reset the table holds one free region of length 0 at base 0.
// A config write is taken only while idle with i_start low; a write to
// CFG_BASE or CFG_LEN reseeds the cells in the next cycle, with o_busy high.
// Results cannot be stalled.
module first_fit_region_allocator_top import ffra_pkg::*; #(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_target_address,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_region_start,
    output logic [31:0] o_region_length,
    output logic        o_is_allocated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_REGIONS);
    localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REGIONS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_REGIONS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_EVAL, S_SPLIT_HI, S_SPLIT_LO,
        S_DROP_UP, S_MERGE_DN, S_DROP_DN, S_REPLY
    } t_state;

    t_state           r_state;
    t_action          r_act;
    logic [31:0]      r_size, r_addr, r_base, r_len;
    logic [IDX_W-1:0] r_i, r_k;
    logic [CNT_W-1:0] r_n;
    logic             r_hit, r_mup, r_mdn, r_seed_pend;
    t_cell_cmd        w_cmd;
    t_entry           w_seed;
    t_entry           w_e [MAX_REGIONS];
    t_entry           w_cur, w_k_e, w_k1_e, w_km_e;
    logic [IDX_W-1:0] w_kp1, w_km1;
    logic [CNT_W-1:0] w_kp1_cnt;
    logic [32:0]      w_room, w_end;
    logic             w_cur_hit, w_up_free, w_dn_free, w_cfg_wr;

    assign w_room = 33'h1_0000_0000 - {1'b0, r_base};
    always_comb begin
        w_seed = '0;
        w_seed.valid = 1'b1;
        w_seed.start = r_base;
        w_seed.length = ({1'b0, r_len} > w_room) ? w_room[31:0] : r_len;
    end

    assign w_cur = w_e[r_i];
    assign w_end = {1'b0, w_cur.start} + {1'b0, w_cur.length};

    // neighbor helpers for split and merge steps
    assign w_kp1     = r_k + IDX_W'(1);
    assign w_km1     = r_k - IDX_W'(1);
    assign w_kp1_cnt = CNT_W'(r_k) + CNT_W'(1);
    assign w_k_e     = w_e[r_k];
    assign w_k1_e    = w_e[w_kp1];
    assign w_km_e    = w_e[w_km1];
    assign w_up_free = (w_kp1_cnt < r_n) && !w_k1_e.used;
    assign w_dn_free = (r_k != '0) && !w_km_e.used;

    assign o_busy      = (r_state != S_IDLE) || r_seed_pend;
    assign o_cfg_ready = !o_busy && !i_start;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready &&
                         (i_cfg_index == 2'(CFG_BASE) || i_cfg_index == 2'(CFG_LEN));

    always_comb begin
        w_cur_hit = 1'b0;
        case (r_act)
            ACT_ALLOC:   w_cur_hit = !w_cur.used && (w_cur.length >= r_size);
            ACT_RELEASE: w_cur_hit = w_cur.used && (w_cur.start == r_addr);
            ACT_CHECK:   w_cur_hit = w_cur.used && ({1'b0, r_addr} >= {1'b0, w_cur.start})
                                     && ({1'b0, r_addr} < w_end);
            default:     w_cur_hit = 1'b0;
        endcase
    end

    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = CC_HOLD;
        w_cmd.k     = 8'(r_k);
        w_cmd.wdata = w_k_e;
        if (r_seed_pend) begin
            w_cmd.op = CC_SEED;
        end else begin
            case (r_state)
                S_EVAL: begin
                    if (r_act == ACT_ALLOC && r_hit && r_size != '0) begin
                        if (w_k_e.length == r_size) begin
                            w_cmd.op = CC_WRITE;
                            w_cmd.wdata.used = 1'b1;
                        end else if (r_n != FULL_CNT) begin
                            // open a slot above the chosen region
                            w_cmd.op = CC_SHIFT_UP;
                        end
                    end else if (r_act == ACT_RELEASE && r_hit) begin
                        w_cmd.op = CC_WRITE;
                        w_cmd.wdata.used = 1'b0;
                        if (w_up_free)
                            w_cmd.wdata.length = w_k_e.length + w_k1_e.length;
                    end
                end
                S_SPLIT_HI: begin
                    w_cmd.op           = CC_WRITE;
                    w_cmd.k            = 8'(w_kp1);
                    w_cmd.wdata.valid  = 1'b1;
                    w_cmd.wdata.used   = 1'b0;
                    w_cmd.wdata.start  = w_k_e.start + r_size;
                    w_cmd.wdata.length = w_k_e.length - r_size;
                end
                S_SPLIT_LO: begin
                    w_cmd.op           = CC_WRITE;
                    w_cmd.wdata.used   = 1'b1;
                    w_cmd.wdata.length = r_size;
                end
                S_DROP_UP: if (r_mup) begin
                    w_cmd.op = CC_SHIFT_DOWN;
                    w_cmd.k  = 8'(w_kp1);
                end
                S_MERGE_DN: if (w_dn_free) begin
                    w_cmd.op           = CC_WRITE;
                    w_cmd.k            = 8'(w_km1);
                    w_cmd.wdata        = w_km_e;
                    w_cmd.wdata.length = w_km_e.length + w_k_e.length;
                end
                S_DROP_DN: if (r_mdn) begin
                    w_cmd.op = CC_SHIFT_DOWN;
                end
                default: w_cmd.op = CC_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_act           <= ACT_NONE;
            r_size          <= '0;
            r_addr          <= '0;
            r_base          <= '0;
            r_len           <= '0;
            r_i             <= '0;
            r_k             <= '0;
            r_n             <= '0;
            r_hit           <= 1'b0;
            r_mup           <= 1'b0;
            r_mdn           <= 1'b0;
            r_seed_pend     <= 1'b0;
            o_done          <= 1'b0;
            o_status        <= ST_OK;
            o_region_start  <= '0;
            o_region_length <= '0;
            o_is_allocated  <= 1'b0;
        end else begin
            o_done      <= (r_state == S_REPLY);
            r_seed_pend <= (r_state == S_IDLE) && w_cfg_wr;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == 2'(CFG_BASE)) begin
                            r_base <= i_cfg_data;
                        end else if (i_cfg_index == 2'(CFG_LEN)) begin
                            r_len <= i_cfg_data;
                        end
                    end else if (i_start && !o_busy) begin
                        r_act           <= t_action'(i_action);
                        r_size          <= i_request_size;
                        r_addr          <= i_target_address;
                        r_i             <= '0;
                        r_n             <= '0;
                        r_hit           <= 1'b0;
                        r_mup           <= 1'b0;
                        r_mdn           <= 1'b0;
                        o_status        <= ST_OK;
                        o_region_start  <= '0;
                        o_region_length <= '0;
                        o_is_allocated  <= 1'b0;
                        r_state         <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_cur.valid) r_n <= r_n + CNT_W'(1);
                    if (w_cur.valid && !r_hit && w_cur_hit) begin
                        r_hit <= 1'b1;
                        r_k   <= r_i;
                    end
                    if (r_i == LAST_IDX) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                S_EVAL: begin
                    case (r_act)
                        ACT_ALLOC: begin
                            if (r_size == '0) begin
                                o_status <= ST_ZERO;
                                r_state  <= S_REPLY;
                            end else if (!r_hit) begin
                                o_status <= ST_NOFIT;
                                r_state  <= S_REPLY;
                            end else if (w_k_e.length == r_size) begin
                                o_region_start  <= w_k_e.start;
                                o_region_length <= r_size;
                                r_state         <= S_REPLY;
                            end else if (r_n == FULL_CNT) begin
                                o_status <= ST_FULL;
                                r_state  <= S_REPLY;
                            end else begin
                                o_region_start  <= w_k_e.start;
                                o_region_length <= r_size;
                                r_state         <= S_SPLIT_HI;
                            end
                        end
                        ACT_RELEASE: begin
                            if (!r_hit) begin
                                o_status <= ST_NOTFOUND;
                                r_state  <= S_REPLY;
                            end else begin
                                o_region_start  <= w_k_e.start;
                                o_region_length <= w_k_e.length;
                                r_mup           <= w_up_free;
                                r_state         <= S_DROP_UP;
                            end
                        end
                        ACT_CHECK: begin
                            o_is_allocated <= r_hit;
                            r_state        <= S_REPLY;
                        end
                        default: r_state <= S_REPLY;
                    endcase
                end
                S_SPLIT_HI: r_state <= S_SPLIT_LO;
                S_SPLIT_LO: r_state <= S_REPLY;
                S_DROP_UP:  r_state <= S_MERGE_DN;
                S_MERGE_DN: begin
                    r_mdn   <= w_dn_free;
                    r_state <= S_DROP_DN;
                end
                S_DROP_DN:  r_state <= S_REPLY;
                S_REPLY:    r_state <= S_IDLE;
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    ffra_chain #(.MAX_REGIONS(MAX_REGIONS), .IDX_W(IDX_W)) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_seed    (w_seed),
        .o_entries (w_e)
    );

endmodule

FILE: rtl/ffra_checker.sv
// Port-level checks for the region allocator, bound to the top level.
module ffra_checker import ffra_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [31:0] o_region_start,
    input logic [31:0] o_region_length,
    input logic        o_is_allocated,
    input logic        o_cfg_ready
);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_region_start == '0 &&
        o_region_length == '0 && !o_is_allocated))
        else $error("error result carries data");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_cfg_ready) else $error("config ready while busy");

endmodule

bind first_fit_region_allocator_top ffra_checker u_ffra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_region_start  (o_region_start),
    .o_region_length (o_region_length),
    .o_is_allocated  (o_is_allocated),
    .o_cfg_ready     (o_cfg_ready)
);
